// ===== rtl/segment_sum_accumulator_assert.svh =====
// Assertion macros for the segment sum accumulator.
// Used by segment_sum_accumulator.sv; expects clk and rst in scope.
`ifndef SEGMENT_SUM_ACCUMULATOR_ASSERT_SVH
`define SEGMENT_SUM_ACCUMULATOR_ASSERT_SVH

// Condition implies check in the same cycle
`define SSA_ASSERT_SAME(label, cond, chk) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
    else $error("segment_sum_accumulator: same-cycle check failed");

// Condition implies check in the next cycle
`define SSA_ASSERT_NEXT(label, cond, chk) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
    else $error("segment_sum_accumulator: next-cycle check failed");

`endif

// ===== rtl/ssacc_pkg.sv =====
// Shared types and constants for the segment sum accumulator.
// No dependencies; imported by segment_sum_accumulator.
`timescale 1ns / 1ps

package ssacc_pkg;

  // Field widths
  localparam int SEG_W   = 6;
  localparam int FEAT_W  = 4;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 40;
  localparam int SEGREG_W  = 7;
  localparam int FEATREG_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Parameter defaults
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_MAX_FEATURES = 16;

  // Register reset values
  localparam logic [SEGREG_W-1:0]  SEGMENTS_RST = 7'd64;
  localparam logic [FEATREG_W-1:0] FEATURES_RST = 5'd16;

  // Saturation limits
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURES = 1'd1;

  // Operation codes
  typedef enum logic [0:0] {
    OP_ACCUM     = 1'b0,
    OP_READ_CLR  = 1'b1
  } op_t;

  // Input word layout, segment in the lowest bits
  typedef struct packed {
    logic [5:0]              pad;
    logic signed [VAL_W-1:0] value;
    logic [FEAT_W-1:0]       feature;
    logic [SEG_W-1:0]        segment;
  } in_word_t;

  // Result flags, saturated in bit 0
  typedef struct packed {
    logic range_error;
    logic saturated;
  } flags_t;

endpackage

// ===== rtl/segment_sum_accumulator.sv =====
// Segment sum scatter-add engine: one sum store, read-modify-write pipeline.
// Depends on ssacc_pkg and segment_sum_accumulator_assert.svh.
`timescale 1ns / 1ps

// Segment sum accumulator. Each input word either adds a signed Q15.16 value into
// the Q23.16 sum at (segment, feature), saturating at 40 bits, or reads that sum
// and clears it; each word returns exactly one result word. After reset the block
// runs a clearing pass over the store, one entry per cycle, with s_tready low;
// configuration writes are taken during that time. Afterwards it sustains one
// word per cycle while the master side is not stalled: the store is a single
// memory with a registered read, the add and write-back happen in the update
// stage that follows the read, and a write-back to the entry that the next word
// reads is forwarded. A result passes from the update stage into the output
// register on the master side. Indices at or above the configured counts return
// sum 0 with range_error set and leave the store alone.
module segment_sum_accumulator
  import ssacc_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // segment[5:0], feature[9:6], value[41:10], zero pad
  input  logic                  s_tuser,   // opcode[0]
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // sum[39:0]
  output logic [1:0]            m_tuser    // saturated[0], range_error[1]
);

  // Usable rows and columns are also bounded by the index field widths
  localparam int SEG_LIM  = (MAX_SEGMENTS < (1 << SEG_W))  ? MAX_SEGMENTS : (1 << SEG_W);
  localparam int FEAT_LIM = (MAX_FEATURES < (1 << FEAT_W)) ? MAX_FEATURES : (1 << FEAT_W);
  localparam int DEPTH    = SEG_LIM * FEAT_LIM;
  localparam int ADDR_W   = $clog2(DEPTH);

  // Configuration registers
  logic [SEGREG_W-1:0]  segments_in_use;
  logic [FEATREG_W-1:0] features_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments_in_use <= SEGMENTS_RST;
      features_in_use <= FEATURES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEGMENTS: segments_in_use <= cfg_data[SEGREG_W-1:0];
        REG_FEATURES: features_in_use <= cfg_data[FEATREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Input decode: range check and store address
  in_word_t          in_w;
  logic              in_err;
  logic [ADDR_W-1:0] in_addr;
  logic              in_acc;

  assign in_w = s_tdata;

  always_comb begin
    in_err = ({1'b0, in_w.segment} >= segments_in_use) ||
             ({1'b0, in_w.segment} >= SEGREG_W'(SEG_LIM)) ||
             ({1'b0, in_w.feature} >= features_in_use) ||
             ({1'b0, in_w.feature} >= FEATREG_W'(FEAT_LIM));
    in_addr = ADDR_W'(ADDR_W'(in_w.segment) * ADDR_W'(FEAT_LIM)) + ADDR_W'(in_w.feature);
  end

  // Update stage registers
  logic                    s1_valid;
  op_t                     s1_op;
  logic                    s1_err;
  logic [ADDR_W-1:0]       s1_addr;
  logic signed [VAL_W-1:0] s1_val;
  logic                    s1_fwd;
  logic signed [SUM_W-1:0] s1_fwd_data;
  logic signed [SUM_W-1:0] mem_q;
  logic                    s1_go;

  assign s1_go    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clr_busy && (!s1_valid || s1_go);
  assign in_acc   = s_tvalid && s_tready;

  // Update: pick the old sum, add with saturation or clear
  logic signed [SUM_W-1:0] old_sum;
  logic signed [SUM_W:0]   wide_sum;
  logic signed [SUM_W-1:0] res_sum;
  logic signed [SUM_W-1:0] wr_val;
  logic                    res_sat;

  always_comb begin
    old_sum  = s1_fwd ? s1_fwd_data : mem_q;
    wide_sum = {old_sum[SUM_W-1], old_sum} +
               {{(SUM_W + 1 - VAL_W){s1_val[VAL_W-1]}}, s1_val};
    res_sat  = 1'b0;
    res_sum  = old_sum;
    wr_val   = '0;
    if (s1_err) begin
      res_sum = '0;
    end else if (s1_op == OP_ACCUM) begin
      if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
        res_sat = 1'b1;
        res_sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        res_sum = wide_sum[SUM_W-1:0];
      end
      wr_val = res_sum;
    end
  end

  // Sum store
  logic signed [SUM_W-1:0] sum_mem [DEPTH];
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_wa;
  logic signed [SUM_W-1:0] mem_wd;

  assign mem_we = clr_busy || (s1_go && !s1_err);
  assign mem_wa = clr_busy ? clr_addr : s1_addr;
  assign mem_wd = clr_busy ? '0 : wr_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q <= sum_mem[in_addr];
    end
  end

  // Update stage control and forwarding from the write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op       <= op_t'(s_tuser);
      s1_err      <= in_err;
      s1_addr     <= in_addr;
      s1_val      <= in_w.value;
      s1_fwd      <= s1_go && !s1_err && (s1_addr == in_addr);
      s1_fwd_data <= wr_val;
    end
  end

  // Output register
  flags_t out_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      m_tdata               <= res_sum;
      out_flags.saturated   <= res_sat;
      out_flags.range_error <= s1_err;
    end
  end

  assign m_tuser = out_flags;

  // Checks
`include "segment_sum_accumulator_assert.svh"

  `SSA_ASSERT_SAME(a_no_accept_in_clear, clr_busy, !s_tready)
  `SSA_ASSERT_SAME(a_err_result_clean, m_tvalid && m_tuser[1], (m_tdata == '0) && !m_tuser[0])
  `SSA_ASSERT_NEXT(a_stalled_item_kept, s1_valid && !s1_go, s1_valid)

endmodule

// ===== bench/tb_segment_sum_accumulator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for segment_sum_accumulator: directed and random words, a
// scatter-add predictor with its own copy of the sum store, and a result checker.
// Depends on ssacc_pkg and the RTL top level only.

module tb_segment_sum_accumulator;
  import ssacc_pkg::*;

  localparam int STORE_DEPTH  = DEF_MAX_SEGMENTS * DEF_MAX_FEATURES;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             saturated;
    logic             range_error;
  } sum_result_t;

  // Predicts each result from a private copy of the store and checks the block
  class segment_sum_checker;
    logic signed [SUM_W-1:0] sum_mirror [STORE_DEPTH];
    int          seg_limit;
    int          feat_limit;
    sum_result_t expected_sums [$];
    int          mismatches;
    int          words_seen;
    int          reads_seen;
    int          clipped_seen;
    int          rejected_seen;

    function new();
      foreach (sum_mirror[i]) sum_mirror[i] = '0;
      seg_limit     = int'(SEGMENTS_RST);
      feat_limit    = int'(FEATURES_RST);
      mismatches    = 0;
      words_seen    = 0;
      reads_seen    = 0;
      clipped_seen  = 0;
      rejected_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SEGMENTS) begin
        seg_limit = int'(data[SEGREG_W-1:0]);
      end else if (idx == REG_FEATURES) begin
        feat_limit = int'(data[FEATREG_W-1:0]);
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // Accepted input word: update the mirror and queue the expected result
    function void note_word(op_t op, logic [SEG_W-1:0] seg, logic [FEAT_W-1:0] feat,
                            logic signed [VAL_W-1:0] val);
      sum_result_t          r;
      int                   idx;
      logic signed [SUM_W+1:0] acc;
      r.sum         = '0;
      r.saturated   = 1'b0;
      r.range_error = 1'b0;
      words_seen++;
      if (int'(seg) >= seg_limit || int'(seg) >= DEF_MAX_SEGMENTS ||
          int'(feat) >= feat_limit || int'(feat) >= DEF_MAX_FEATURES) begin
        r.range_error = 1'b1;
        rejected_seen++;
      end else begin
        idx = int'(seg) * DEF_MAX_FEATURES + int'(feat);
        if (op == OP_READ_CLR) begin
          r.sum = sum_mirror[idx];
          sum_mirror[idx] = '0;
          reads_seen++;
        end else begin
          acc = sum_mirror[idx] + val;
          if (acc > SUM_MAX) begin
            acc = SUM_MAX;
            r.saturated = 1'b1;
          end else if (acc < SUM_MIN) begin
            acc = SUM_MIN;
            r.saturated = 1'b1;
          end
          if (r.saturated) clipped_seen++;
          sum_mirror[idx] = acc[SUM_W-1:0];
          r.sum = acc[SUM_W-1:0];
        end
      end
      expected_sums.push_back(r);
    endfunction

    // Accepted result word: compare against the oldest expectation
    function void check_word(logic [SUM_W-1:0] got_sum, flags_t got_flags);
      sum_result_t want;
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result with nothing expected: sum=%h flags=%b",
                   $realtime, got_sum, got_flags);
        return;
      end
      want = expected_sums.pop_front();
      if (got_sum !== want.sum || got_flags.saturated !== want.saturated ||
          got_flags.range_error !== want.range_error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] mismatch: sum exp %h got %h, sat exp %b got %b, rerr exp %b got %b",
                   $realtime, want.sum, got_sum, want.saturated, got_flags.saturated,
                   want.range_error, got_flags.range_error);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [47:0]           s_tdata;   // segment[5:0], feature[9:6], value[41:10], zero pad
  logic                  s_tuser;   // opcode[0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;   // sum[39:0]
  logic [1:0]            m_tuser;   // saturated[0], range_error[1]

  segment_sum_accumulator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  segment_sum_checker sums = new();

  int send_idle_pct = 35;
  int recv_idle_pct = 46;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;
  int cycle_count   = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sums.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sums.check_word(m_tdata, flags_t'(m_tuser));
  end

  // Receiver: random backpressure, plus one long hold-off on request
  initial begin : receiver
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one word with random gaps; returns at the edge where it is taken
  task automatic send_word(op_t op, int seg, int feat, logic [31:0] val);
    in_word_t word;
    word.pad     = '0;
    word.segment = seg[SEG_W-1:0];
    word.feature = feat[FEAT_W-1:0];
    word.value   = val;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sums.note_word(op, word.segment, word.feature, word.value);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    sums.set_register(idx, data[CFG_DATA_W-1:0]);
  endtask

  // Drain all results, then reprogram both limits
  task automatic set_limits(int segs, int feats);
    s_tvalid <= 1'b0;
    while (sums.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_SEGMENTS, segs);
    write_reg(REG_FEATURES, feats);
    cfg_we <= 1'b0;
  endtask

  // Random words; about half pile extreme values onto one hot entry so it clips
  task automatic random_phase(int n_items, bit neg_hot, int hot_seg, int hot_feat,
                              bit with_hold);
    int   eff_seg;
    int   eff_feat;
    int   pick;
    int   seg;
    int   feat;
    op_t  op;
    logic [31:0] val;
    eff_seg  = (sums.seg_limit < DEF_MAX_SEGMENTS) ? sums.seg_limit : DEF_MAX_SEGMENTS;
    eff_feat = (sums.feat_limit < DEF_MAX_FEATURES) ? sums.feat_limit : DEF_MAX_FEATURES;
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 2) hold_off_req = 1'b1;
      pick = $urandom_range(0, 99);
      val  = $urandom;
      op   = OP_ACCUM;
      if (pick < 50) begin
        seg  = hot_seg;
        feat = hot_feat;
        val  = neg_hot ? 32'h8000_0000 + $urandom_range(0, 1023)
                       : 32'h7FFF_FFFF - $urandom_range(0, 1023);
      end else if (pick < 88) begin
        seg  = $urandom_range(0, eff_seg - 1);
        feat = $urandom_range(0, eff_feat - 1);
        if ($urandom_range(0, 3) == 0) op = OP_READ_CLR;
      end else begin
        seg  = $urandom_range(0, 63);
        feat = $urandom_range(0, 15);
        op   = op_t'($urandom_range(0, 1));
      end
      // keep the hot entry climbing until the phase closes
      if (seg == hot_seg && feat == hot_feat) op = OP_ACCUM;
      send_word(op, seg, feat, val);
    end
    send_word(OP_READ_CLR, hot_seg, hot_feat, $urandom);
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and both operations at reset limits
    send_word(OP_ACCUM,    0,  0, 32'h0000_0001);
    send_word(OP_ACCUM,    0,  0, 32'h7FFF_FFFF);
    send_word(OP_ACCUM,    0,  0, 32'h8000_0000);
    send_word(OP_READ_CLR, 0,  0, 32'h0000_0000);
    send_word(OP_READ_CLR, 0,  0, 32'hFFFF_FFFF);
    send_word(OP_ACCUM,   63, 15, 32'hFFFF_FFFF);
    send_word(OP_READ_CLR,63, 15, 32'h1234_5678);
    send_word(OP_READ_CLR,63, 15, 32'h1234_5678);
    send_word(OP_ACCUM,   21,  5, 32'h5555_5555);
    send_word(OP_ACCUM,   42, 10, 32'hAAAA_AAAA);
    send_word(OP_READ_CLR,21,  5, 32'h0);
    send_word(OP_READ_CLR,42, 10, 32'h0);

    // Zero limits reject every index
    set_limits(0, 0);
    send_word(OP_ACCUM,    0,  0, 32'h0000_0005);
    send_word(OP_READ_CLR, 0,  0, 32'h0);
    send_word(OP_ACCUM,   63, 15, 32'h7FFF_FFFF);

    // Single-entry store: only (0,0) passes
    set_limits(1, 1);
    send_word(OP_ACCUM,    0,  0, 32'h0000_0007);
    send_word(OP_ACCUM,    1,  0, 32'h0000_0007);
    send_word(OP_ACCUM,    0,  1, 32'h0000_0007);
    send_word(OP_READ_CLR, 0,  0, 32'h0);
    send_word(OP_READ_CLR, 0,  0, 32'h0);

    // Limits above range fall back to the parameters; hot entry clips high
    set_limits(127, 31);
    random_phase(640, 1'b0, 63, 15, 1'b0);

    // Small window, idling swapped; hot entry clips low
    set_limits(5, 3);
    send_idle_pct = 46;
    recv_idle_pct = 35;
    random_phase(640, 1'b1, 2, 1, 1'b0);

    // Full store, no idling, one long receiver hold-off
    set_limits(64, 16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(620, 1'b0, 30, 9, 1'b1);

    s_tvalid <= 1'b0;
    while (sums.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d words under five limit settings: %0d read-and-clear, %0d clipped sums,",
             sums.words_seen, sums.reads_seen, sums.clipped_seen);
    $display("%0d rejected indices, with a %0d-cycle receiver hold-off; %0d mismatches",
             sums.rejected_seen, HOLD_CYCLES, sums.mismatches);
    if (sums.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
